/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ZEHT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ZEHT_ASSERT_CLK(lbl, prop) `ZEHT_ASSERT(lbl, clk_i, rst_ni, prop)
`else
`define ZEHT_ASSERT(lbl, clk, rst_n, prop)
`define ZEHT_ASSERT_CLK(lbl, prop)
`endif

`endif

/* src/zeht_pkg.sv */
// ----------------------------------------------------------------------------
// zeht package
// constants, types and arctangent table for the euler to transform block
// ----------------------------------------------------------------------------
package zeht_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int NUM_CELLS     = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                 : ATAN_ENTRIES;
  localparam int AW    = 34;
  localparam int SH_W  = 5;
  localparam int POS_W = 32;
  localparam int IN_W  = 144;
  localparam int OUT_W = 240;

  localparam logic signed [AW-1:0] ANG_PI      = 34'sd3373259426;
  localparam logic signed [AW-1:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [AW-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [AW-1:0] x;
    logic signed [AW-1:0] y;
    logic signed [AW-1:0] z;
  } zeht_rot_t;

  typedef struct packed {
    zeht_rot_t [2:0]      rot;
    logic [2:0]           neg;
    logic [3*POS_W-1:0]   pos;
  } zeht_cell_t;

  function automatic logic signed [AW-1:0] atan_q30(input logic [SH_W-1:0] idx);
    logic signed [AW-1:0] r;
    case (idx)
      5'd0:    r = 34'sd843314856;
      5'd1:    r = 34'sd497837829;
      5'd2:    r = 34'sd263043836;
      5'd3:    r = 34'sd133525158;
      5'd4:    r = 34'sd67021686;
      5'd5:    r = 34'sd33543515;
      5'd6:    r = 34'sd16775850;
      5'd7:    r = 34'sd8388437;
      5'd8:    r = 34'sd4194282;
      5'd9:    r = 34'sd2097149;
      5'd10:   r = 34'sd1048575;
      5'd11:   r = 34'sd524287;
      5'd12:   r = 34'sd262143;
      5'd13:   r = 34'sd131071;
      5'd14:   r = 34'sd65535;
      5'd15:   r = 34'sd32767;
      5'd16:   r = 34'sd16383;
      5'd17:   r = 34'sd8191;
      5'd18:   r = 34'sd4095;
      5'd19:   r = 34'sd2047;
      5'd20:   r = 34'sd1023;
      5'd21:   r = 34'sd511;
      5'd22:   r = 34'sd255;
      5'd23:   r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* src/zyx_euler_to_homogeneous_transform.sv */
// ----------------------------------------------------------------------------
// zyx euler to homogeneous transform
// rotation rz*ry*rx in q1.14 plus pass-through translation
// ----------------------------------------------------------------------------
// Takes one pose per cycle and returns one 3x4 transform per pose, in order.
// The pipeline is an angle fold register, one cordic cell per micro-rotation
// (16 cordic cells), then rounding, two product stages and the output
// register. The whole pipeline advances together and holds while a result
// waits on m_axis_tready_i.
`include "assert_macros.svh"

module zyx_euler_to_homogeneous_transform (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // roll, pitch, yaw (16 each), pos_x, pos_y, pos_z (32 each)
  input  logic [zeht_pkg::IN_W-1:0]   s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // r00 r01 r02 r10 r11 r12 r20 r21 r22 (16 each), t_x, t_y, t_z (32 each)
  output logic [zeht_pkg::OUT_W-1:0]  m_axis_tdata_o
);
  import zeht_pkg::*;

  logic       adv;
  logic       out_vld;
  zeht_cell_t prep_d;
  zeht_cell_t chain_dat [NUM_CELLS+1];
  logic       chain_vld [NUM_CELLS+1];
  logic       prep_vld_q;
  zeht_cell_t prep_q;
  logic signed [AW-1:0] z0;

  assign adv             = !out_vld || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // scale to q2.30 and fold into plus or minus half pi
  always_comb begin
    prep_d.pos = s_axis_tdata_i[IN_W-1:48];
    for (int l = 0; l < 3; l++) begin
      z0 = $signed({s_axis_tdata_i[16*l+15], s_axis_tdata_i[16*l +: 16], 17'b0});
      prep_d.rot[l].x = CORDIC_GAIN;
      prep_d.rot[l].y = '0;
      if (z0 > ANG_HALF_PI) begin
        prep_d.rot[l].z = z0 - ANG_PI;
        prep_d.neg[l]   = 1'b1;
      end else if (z0 < -ANG_HALF_PI) begin
        prep_d.rot[l].z = z0 + ANG_PI;
        prep_d.neg[l]   = 1'b1;
      end else begin
        prep_d.rot[l].z = z0;
        prep_d.neg[l]   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_vld_q <= 1'b0;
    end else if (adv) begin
      prep_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prep_q <= prep_d;
    end
  end

  assign chain_dat[0] = prep_q;
  assign chain_vld[0] = prep_vld_q;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    zeht_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .vld_i   (chain_vld[i]),
      .shift_i (SH_W'(i)),
      .atan_i  (atan_q30(SH_W'(i))),
      .data_i  (chain_dat[i]),
      .vld_o   (chain_vld[i+1]),
      .data_o  (chain_dat[i+1])
    );
  end

  zeht_mat u_mat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .vld_i   (chain_vld[NUM_CELLS]),
    .data_i  (chain_dat[NUM_CELLS]),
    .vld_o   (out_vld),
    .tdata_o (m_axis_tdata_o)
  );

  assign m_axis_tvalid_o = out_vld;

  `ZEHT_ASSERT_CLK(a_freeze_on_stall, (out_vld && !m_axis_tready_i) |-> !s_axis_tready_o)
  `ZEHT_ASSERT_CLK(a_accept_enters, (s_axis_tvalid_i && s_axis_tready_o) |=> prep_vld_q)
  `ZEHT_ASSERT_CLK(a_prep_hold, !adv |=> $stable(prep_vld_q))

endmodule

/* src/zeht_cell.sv */
// ----------------------------------------------------------------------------
// zeht cordic cell
// one rotation-mode cordic micro-rotation for all three angles
// ----------------------------------------------------------------------------
module zeht_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  logic [zeht_pkg::SH_W-1:0]           shift_i,
  input  logic signed [zeht_pkg::AW-1:0]      atan_i,
  input  zeht_pkg::zeht_cell_t                data_i,
  output logic                                vld_o,
  output zeht_pkg::zeht_cell_t                data_o
);
  import zeht_pkg::*;

  zeht_cell_t           data_d, data_q;
  logic                 vld_q;
  logic signed [AW-1:0] sx [3];
  logic signed [AW-1:0] sy [3];

  always_comb begin
    data_d = data_i;
    for (int l = 0; l < 3; l++) begin
      sx[l] = data_i.rot[l].x >>> shift_i;
      sy[l] = data_i.rot[l].y >>> shift_i;
      if (!data_i.rot[l].z[AW-1]) begin
        data_d.rot[l].x = data_i.rot[l].x - sy[l];
        data_d.rot[l].y = data_i.rot[l].y + sx[l];
        data_d.rot[l].z = data_i.rot[l].z - atan_i;
      end else begin
        data_d.rot[l].x = data_i.rot[l].x + sy[l];
        data_d.rot[l].y = data_i.rot[l].y - sx[l];
        data_d.rot[l].z = data_i.rot[l].z + atan_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

/* src/zeht_mat.sv */
// ----------------------------------------------------------------------------
// zeht matrix stages
// sine/cosine rounding and the rotation product pipeline
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module zeht_mat (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  zeht_pkg::zeht_cell_t          data_i,
  output logic                          vld_o,
  output logic [zeht_pkg::OUT_W-1:0]    tdata_o
);
  import zeht_pkg::*;

  function automatic logic signed [15:0] sat_q14(input logic signed [49:0] v);
    logic signed [15:0] r;
    if (v > 50'sd16384) r = 16'sd16384;
    else if (v < -50'sd16384) r = -16'sd16384;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [15:0] rnd2(input logic signed [31:0] p);
    logic signed [49:0] v;
    v = (50'(p) + 50'sd8192) >>> 14;
    return sat_q14(v);
  endfunction

  function automatic logic signed [15:0] rnd3(input logic signed [49:0] p);
    logic signed [49:0] v;
    v = (p + 50'sd134217728) >>> 28;
    return sat_q14(v);
  endfunction

  // stage s: sine and cosine, order cr sr cp sp cy sy
  logic signed [15:0]  cs_d [6];
  logic signed [15:0]  cs_q [6];
  logic [3*POS_W-1:0]  pos_s_q;
  logic                vld_s_q;
  logic signed [AW-1:0] vx, vy;
  logic signed [AW:0]   rx, ry;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      vx = data_i.neg[l] ? -data_i.rot[l].x : data_i.rot[l].x;
      vy = data_i.neg[l] ? -data_i.rot[l].y : data_i.rot[l].y;
      rx = ((AW+1)'(vx) + 35'sd32768) >>> 16;
      ry = ((AW+1)'(vy) + 35'sd32768) >>> 16;
      cs_d[2*l]   = sat_q14(50'(rx));
      cs_d[2*l+1] = sat_q14(50'(ry));
    end
  end

  // stage a: pairwise products
  logic signed [31:0] crcp_q, srcp_q, cpsy_q, cpcy_q, spsy_q, spcy_q;
  logic signed [31:0] crcy_q, srsy_q, srcy_q, crsy_q;
  logic signed [15:0] cr_a_q, sr_a_q, sp_a_q;
  logic [3*POS_W-1:0] pos_a_q;
  logic               vld_a_q;

  // stage b: triple products and single-product entries
  logic signed [47:0] q1_q, q2_q, q3_q, q4_q;
  logic signed [31:0] srcy_b_q, srsy_b_q, crcy_b_q, crsy_b_q;
  logic signed [15:0] m0_q, m3_q, m6_q, m7_q, m8_q;
  logic [3*POS_W-1:0] pos_b_q;
  logic               vld_b_q;

  // stage c: output register
  logic [OUT_W-1:0]   out_q;
  logic               vld_c_q;
  logic signed [15:0] m1, m2, m4, m5;

  assign m1 = rnd3(50'(q1_q) - (50'(srcy_b_q) <<< 14));
  assign m2 = rnd3((50'(srsy_b_q) <<< 14) + 50'(q3_q));
  assign m4 = rnd3((50'(crcy_b_q) <<< 14) + 50'(q2_q));
  assign m5 = rnd3(50'(q4_q) - (50'(crsy_b_q) <<< 14));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s_q <= 1'b0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else if (en_i) begin
      vld_s_q <= vld_i;
      vld_a_q <= vld_s_q;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 6; k++) begin
        cs_q[k] <= cs_d[k];
      end
      pos_s_q <= data_i.pos;

      crcp_q  <= cs_q[0] * cs_q[2];
      srcp_q  <= cs_q[1] * cs_q[2];
      cpsy_q  <= cs_q[2] * cs_q[5];
      cpcy_q  <= cs_q[2] * cs_q[4];
      spsy_q  <= cs_q[3] * cs_q[5];
      spcy_q  <= cs_q[3] * cs_q[4];
      crcy_q  <= cs_q[0] * cs_q[4];
      srsy_q  <= cs_q[1] * cs_q[5];
      srcy_q  <= cs_q[1] * cs_q[4];
      crsy_q  <= cs_q[0] * cs_q[5];
      cr_a_q  <= cs_q[0];
      sr_a_q  <= cs_q[1];
      sp_a_q  <= cs_q[3];
      pos_a_q <= pos_s_q;

      q1_q     <= cr_a_q * spsy_q;
      q2_q     <= sr_a_q * spsy_q;
      q3_q     <= cr_a_q * spcy_q;
      q4_q     <= sr_a_q * spcy_q;
      srcy_b_q <= srcy_q;
      srsy_b_q <= srsy_q;
      crcy_b_q <= crcy_q;
      crsy_b_q <= crsy_q;
      m0_q     <= rnd2(crcp_q);
      m3_q     <= rnd2(srcp_q);
      m6_q     <= -sp_a_q;
      m7_q     <= rnd2(cpsy_q);
      m8_q     <= rnd2(cpcy_q);
      pos_b_q  <= pos_a_q;

      out_q <= {pos_b_q, m8_q, m7_q, m6_q, m5, m4, m3_q, m2, m1, m0_q};
    end
  end

  assign vld_o   = vld_c_q;
  assign tdata_o = out_q;

  `ZEHT_ASSERT_CLK(a_r00_range,
    vld_c_q |-> ($signed(out_q[15:0]) <= 16'sd16384 && $signed(out_q[15:0]) >= -16'sd16384))
  `ZEHT_ASSERT_CLK(a_stall_hold, !en_i |=> $stable(out_q) && $stable(vld_c_q))
  `ZEHT_ASSERT_CLK(a_vld_flow, en_i && vld_b_q |=> vld_c_q)

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// zyx euler to homogeneous transform testbench
// drives poses over the input stream, predicts each 3x4 transform with a
// bit-exact cordic and product model, and checks results in order under
// random idling on both sides and one long output hold-off
// ----------------------------------------------------------------------------
module tb;
  import zeht_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam logic signed [15:0] ANG_MAX = 16'sd25736;

  typedef struct packed {
    logic signed [31:0] pz;
    logic signed [31:0] py;
    logic signed [31:0] px;
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
  } pose_t;

  typedef struct packed {
    logic signed [31:0] tz;
    logic signed [31:0] ty;
    logic signed [31:0] tx;
    logic signed [15:0] r22;
    logic signed [15:0] r21;
    logic signed [15:0] r20;
    logic signed [15:0] r12;
    logic signed [15:0] r11;
    logic signed [15:0] r10;
    logic signed [15:0] r02;
    logic signed [15:0] r01;
    logic signed [15:0] r00;
  } xform_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [IN_W-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata_o;

  xform_t expected_xforms[$];
  int errors = 0;
  int idle_cycles = 0;
  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  bit long_hold_req = 1'b0;
  int hold_off = 0;

  always #1 clk_i = ~clk_i;

  zyx_euler_to_homogeneous_transform dut (.*);

  function automatic longint atan_tab(int i);
    case (i)
      0: return 843314856;  1: return 497837829;  2: return 263043836;
      3: return 133525158;  4: return 67021686;   5: return 33543515;
      6: return 16775850;   7: return 8388437;    8: return 4194282;
      9: return 2097149;    10: return 1048575;   11: return 524287;
      12: return 262143;    13: return 131071;    14: return 65535;
      15: return 32767;     16: return 16383;     17: return 8191;
      18: return 4095;      19: return 2047;      20: return 1023;
      21: return 511;       22: return 255;       23: return 127;
      default: return 0;
    endcase
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic void cordic_sin_cos(logic signed [15:0] ang, output longint c,
                                         output longint s);
    longint z, x, y, nx, ny;
    bit flip;
    z = longint'(ang) * 131072;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1'b1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= atan_tab(i);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += atan_tab(i);
      end
      x = nx;
      y = ny;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clamp_unit((x + 32768) >>> 16);
    s = clamp_unit((y + 32768) >>> 16);
  endfunction

  function automatic xform_t predict_xform(pose_t p);
    longint cr, sr, cp, sp, cy, sy;
    xform_t r;
    cordic_sin_cos(p.roll, cr, sr);
    cordic_sin_cos(p.pitch, cp, sp);
    cordic_sin_cos(p.yaw, cy, sy);
    r.r00 = 16'(clamp_unit((cr * cp + 8192) >>> 14));
    r.r01 = 16'(clamp_unit((cr * sp * sy - sr * cy * 16384 + 134217728) >>> 28));
    r.r02 = 16'(clamp_unit((sr * sy * 16384 + cr * sp * cy + 134217728) >>> 28));
    r.r10 = 16'(clamp_unit((sr * cp + 8192) >>> 14));
    r.r11 = 16'(clamp_unit((cr * cy * 16384 + sr * sp * sy + 134217728) >>> 28));
    r.r12 = 16'(clamp_unit((sr * sp * cy - cr * sy * 16384 + 134217728) >>> 28));
    r.r20 = 16'(-sp);
    r.r21 = 16'(clamp_unit((cp * sy + 8192) >>> 14));
    r.r22 = 16'(clamp_unit((cp * cy + 8192) >>> 14));
    r.tx = p.px;
    r.ty = p.py;
    r.tz = p.pz;
    return r;
  endfunction

  task automatic send_pose(pose_t p);
    int gap;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= p;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_xforms = {expected_xforms, predict_xform(p)};
  endtask

  task automatic stop_sending();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_angle();
    return $signed(16'($urandom_range(0, 2 * 25736))) - ANG_MAX;
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    p.roll = rand_angle();
    p.pitch = rand_angle();
    p.yaw = rand_angle();
    p.px = $urandom;
    p.py = $urandom;
    p.pz = $urandom;
    return p;
  endfunction

  function automatic pose_t make_pose(int r, int pi, int y, int x);
    pose_t p;
    p.roll = 16'(r);
    p.pitch = 16'(pi);
    p.yaw = 16'(y);
    p.px = x;
    p.py = ~x;
    p.pz = x ^ 32'h5a5a_a5a5;
    return p;
  endfunction

  // output side: random stalls and an optional long hold-off
  always @(posedge clk_i) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_off <= 200;
      m_axis_tready_i <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready_i <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      hold_off <= $urandom_range(0, 16);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    xform_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (expected_xforms.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = expected_xforms.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    int angs[8] = '{0, 25736, -25736, 12868, -12868, 12869, -12869, -32768};
    foreach (angs[i]) send_pose(make_pose(angs[i], 0, 0, 32'h7fff_ffff));
    foreach (angs[i]) send_pose(make_pose(0, angs[i], 0, 32'h8000_0000));
    send_pose(make_pose(0, 0, 32767, 0));
    send_pose(make_pose(32767, 32767, 32767, -1));
    send_pose(make_pose(-32768, -32768, -32768, 1));
    send_pose(make_pose(6434, 12868, -6434, 32'h0001_0000));
    send_pose(make_pose(-25736, 25736, 12868, 32'hffff_0000));
    stop_sending();
  endtask

  task automatic test_random();
    pose_t p;
    for (int n = 0; n < 450; n++) begin
      p = rand_pose();
      // a few angles over the whole 16-bit range
      if ($urandom_range(0, 9) == 0) p.roll = 16'($urandom);
      if ($urandom_range(0, 9) == 0) p.yaw = 16'($urandom);
      if ($urandom_range(0, 9) == 0) p.pitch = 16'($urandom);
      send_pose(p);
    end
    stop_sending();
  endtask

  task automatic test_backpressure();
    @(posedge clk_i);
    long_hold_req = 1'b1;
    src_idle_en = 1'b0;
    for (int n = 0; n < 50; n++) send_pose(rand_pose());
    stop_sending();
  endtask

  task automatic test_full_rate();
    sink_idle_en = 1'b0;
    for (int n = 0; n < 50; n++) send_pose(rand_pose());
    stop_sending();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    test_full_rate();
    while (expected_xforms.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
